### design/four_stream_timestamp_aligner_top_defines.svh
// Assertion macros shared by the timestamp aligner RTL.
`ifndef FOUR_STREAM_TIMESTAMP_ALIGNER_TOP_DEFINES_SVH
`define FOUR_STREAM_TIMESTAMP_ALIGNER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked at every rising edge outside reset.
`define FSTA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// Checked at every rising edge, reset included.
`define FSTA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define FSTA_ASSERT(lbl, clk, rst_n, prop)
`define FSTA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### design/fsta_pkg.sv
// Types and constants shared by the timestamp aligner modules.
package fsta_pkg;

  localparam int unsigned NumStreams    = 4;
  localparam int unsigned StreamBits    = 2;
  localparam int unsigned StampBits     = 48;
  localparam int unsigned InTagBits     = 16;
  localparam int unsigned OutTagBits    = 16;
  localparam int unsigned TolBits       = 32;
  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned TagBitsDef    = 16;
  localparam logic [TolBits-1:0] TolReset = 32'd10000000;
  localparam int unsigned OutDataBits   = NumStreams * (StampBits + OutTagBits);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CHECK,
    ST_LOAD,
    ST_DECIDE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // capture the input transfer
    logic push;   // append the captured frame to its queue
    logic load;   // register min, max and oldest stream of the heads
    logic emit;   // send the four heads and pop them
    logic drop;   // pop the oldest head
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic all_filled;
    logic in_tol;
    logic out_busy;
  } sts_t;

endpackage

### design/four_stream_timestamp_aligner_top.sv
// Top level of the four-stream timestamp aligner.
// After its input transfer a frame is written to its queue and the fill levels are checked;
// while a queue is empty the next input can then be taken. Once all four queues hold a frame,
// each stale head dropped repeats the head read, compare and spread check, and a finished
// set may wait for the output register to be free before it is sent and the next input taken.
// Reset (rst_ni low, asynchronous) empties all queues and restores the tolerance.
module four_stream_timestamp_aligner_top #(
  parameter int unsigned QUEUE_DEPTH = fsta_pkg::QueueDepthDef,
  parameter int unsigned TAG_BITS    = fsta_pkg::TagBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input frames.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // From bit 0: frame_stamp (48), frame_tag (16).
  input  logic [63:0]                      s_axis_tdata,
  // From bit 0: stream_index (2).
  input  logic [fsta_pkg::StreamBits-1:0]  s_axis_tuser,
  // Synchronized sets.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // From bit 0: stamp_zero, stamp_one, stamp_two, stamp_three (48 each),
  // tag_zero, tag_one, tag_two, tag_three (16 each).
  output logic [fsta_pkg::OutDataBits-1:0] m_axis_tdata,
  // Tolerance register write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fsta_pkg::TolBits-1:0]     cfg_data_i
);
  import fsta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The tolerance register takes a transfer in any cycle; the user must change it only while
  // no frame is in flight, as the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  // The controller walks each frame through write, head read, compare and
  // decide; a failed spread check drops the oldest head and loops back to
  // the head read while all four queues still hold a frame.
  fsta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the four queue RAMs, their pointers and fill levels,
  // the head comparison and the output register. A finished set may wait in
  // the output register while the next frame is already being taken; only a
  // second set waits for the first to leave.
  fsta_datapath #(
    .QueueDepth (QUEUE_DEPTH),
    .TagBits    (TAG_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_stream_i (s_axis_tuser),
    .in_stamp_i  (s_axis_tdata[StampBits-1:0]),
    .in_tag_i    (s_axis_tdata[StampBits +: InTagBits]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### design/fsta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/fsta_ctrl.sv
// Sequencing state machine of the timestamp aligner.
module fsta_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fsta_pkg::sts_t sts_i,
  output fsta_pkg::cmd_t cmd_o
);
  import fsta_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_WRITE;
      end
      ST_WRITE: state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = sts_i.all_filled ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!sts_i.in_tol) begin
          state_d = ST_CHECK;
        end else if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_WRITE: cmd_o.push = 1'b1;
      ST_CHECK: ;
      ST_LOAD:  cmd_o.load = 1'b1;
      ST_DECIDE: begin
        cmd_o.drop = !sts_i.in_tol;
        cmd_o.emit = sts_i.in_tol && !sts_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

### design/fsta_datapath.sv
// Frame queues, head comparison and output register of the timestamp aligner.
`include "four_stream_timestamp_aligner_top_defines.svh"
module fsta_datapath #(
  parameter int unsigned QueueDepth = fsta_pkg::QueueDepthDef,
  parameter int unsigned TagBits    = fsta_pkg::TagBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fsta_pkg::cmd_t                  cmd_i,
  output fsta_pkg::sts_t                  sts_o,
  input  logic [fsta_pkg::StreamBits-1:0] in_stream_i,
  input  logic [fsta_pkg::StampBits-1:0]  in_stamp_i,
  input  logic [fsta_pkg::InTagBits-1:0]  in_tag_i,
  input  logic                            cfg_valid_i,
  input  logic [fsta_pkg::TolBits-1:0]    cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [fsta_pkg::OutDataBits-1:0] out_data_o
);
  import fsta_pkg::*;

  localparam int unsigned AddrW  = $clog2(QueueDepth);
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);
  localparam int unsigned SumW   = AddrW + 1;
  localparam int unsigned EntryW = StampBits + TagBits;

  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] a);
    logic [AddrW-1:0] r;
    r = (a == AddrW'(QueueDepth - 1)) ? '0 : a + AddrW'(1);
    return r;
  endfunction

  logic [TolBits-1:0]    tol_q;
  logic [AddrW-1:0]      head_q [NumStreams];
  logic [AddrW-1:0]      head_d [NumStreams];
  logic [CntW-1:0]       cnt_q  [NumStreams];
  logic [CntW-1:0]       cnt_d  [NumStreams];
  logic [StreamBits-1:0] stream_q;
  logic [StampBits-1:0]  stamp_q;
  logic [TagBits-1:0]    tag_q;
  logic [StampBits-1:0]  tmin_q, tmax_q;
  logic [StreamBits-1:0] oldest_q;
  logic                  out_valid_q;
  logic [OutDataBits-1:0] out_data_q;

  logic [EntryW-1:0]     rdata [NumStreams];
  logic [StampBits-1:0]  hstamp [NumStreams];
  logic [OutTagBits-1:0] htag [NumStreams];
  logic [SumW-1:0]       tail_sum;
  logic [AddrW-1:0]      tail;
  logic                  full;
  logic                  all_filled;

  // Input capture and tolerance register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      stream_q <= in_stream_i;
      stamp_q  <= in_stamp_i;
      tag_q    <= TagBits'(in_tag_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // Write position: head plus count, wrapped once.
  assign tail_sum = SumW'(head_q[stream_q]) + SumW'(cnt_q[stream_q]);
  assign tail     = (tail_sum >= SumW'(QueueDepth)) ?
                    AddrW'(tail_sum - SumW'(QueueDepth)) : AddrW'(tail_sum);
  assign full     = (cnt_q[stream_q] == CntW'(QueueDepth));

  for (genvar g = 0; g < NumStreams; g++) begin : g_queue
    fsta_ram #(
      .Width (EntryW),
      .Depth (QueueDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.push && (stream_q == StreamBits'(g))),
      .waddr_i (tail),
      .wdata_i ({stamp_q, tag_q}),
      .raddr_i (head_q[g]),
      .rdata_o (rdata[g])
    );
    assign hstamp[g] = rdata[g][EntryW-1 -: StampBits];
    assign htag[g]   = OutTagBits'(rdata[g][TagBits-1:0]);
  end

  always_comb begin
    all_filled = 1'b1;
    for (int s = 0; s < NumStreams; s++) begin
      if (cnt_q[s] == '0) all_filled = 1'b0;
    end
  end

  // Pointer and fill level updates.
  always_comb begin
    for (int s = 0; s < NumStreams; s++) begin
      head_d[s] = head_q[s];
      cnt_d[s]  = cnt_q[s];
    end
    if (cmd_i.push) begin
      if (full) begin
        head_d[stream_q] = wrap_inc(head_q[stream_q]);
      end else begin
        cnt_d[stream_q] = cnt_q[stream_q] + CntW'(1);
      end
    end else if (cmd_i.emit) begin
      for (int s = 0; s < NumStreams; s++) begin
        head_d[s] = wrap_inc(head_q[s]);
        cnt_d[s]  = cnt_q[s] - CntW'(1);
      end
    end else if (cmd_i.drop) begin
      head_d[oldest_q] = wrap_inc(head_q[oldest_q]);
      cnt_d[oldest_q]  = cnt_q[oldest_q] - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumStreams; s++) begin
        head_q[s] <= '0;
        cnt_q[s]  <= '0;
      end
    end else begin
      for (int s = 0; s < NumStreams; s++) begin
        head_q[s] <= head_d[s];
        cnt_q[s]  <= cnt_d[s];
      end
    end
  end

  // Min and max over the four heads as a two-level tree. Strict less-than
  // keeps the lower stream on ties.
  logic                  lo01, lo23, lofin, hi01, hi23;
  logic [StampBits-1:0]  m01, m23, x01, x23;
  logic [StreamBits-1:0] i01, i23;

  always_comb begin
    lo01  = hstamp[1] < hstamp[0];
    m01   = lo01 ? hstamp[1] : hstamp[0];
    i01   = lo01 ? StreamBits'(1) : StreamBits'(0);
    lo23  = hstamp[3] < hstamp[2];
    m23   = lo23 ? hstamp[3] : hstamp[2];
    i23   = lo23 ? StreamBits'(3) : StreamBits'(2);
    lofin = m23 < m01;
    hi01  = hstamp[1] > hstamp[0];
    x01   = hi01 ? hstamp[1] : hstamp[0];
    hi23  = hstamp[3] > hstamp[2];
    x23   = hi23 ? hstamp[3] : hstamp[2];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tmin_q   <= lofin ? m23 : m01;
      oldest_q <= lofin ? i23 : i01;
      tmax_q   <= (x23 > x01) ? x23 : x01;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {htag[3], htag[2], htag[1], htag[0],
                     hstamp[3], hstamp[2], hstamp[1], hstamp[0]};
    end
  end

  assign sts_o.all_filled = all_filled;
  assign sts_o.in_tol     = (tmax_q - tmin_q) <= StampBits'(tol_q);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;

  `FSTA_ASSERT(a_cnt_bound, clk_i, rst_ni, (cnt_q[0] <= CntW'(QueueDepth)) && (cnt_q[1] <= CntW'(QueueDepth)) && (cnt_q[2] <= CntW'(QueueDepth)) && (cnt_q[3] <= CntW'(QueueDepth)))
  `FSTA_ASSERT(a_emit_valid, clk_i, rst_ni, cmd_i.emit |=> out_valid_q)
  `FSTA_ASSERT(a_emit_filled, clk_i, rst_ni, cmd_i.emit |-> (all_filled && sts_o.in_tol))
  `FSTA_ASSERT(a_drop_filled, clk_i, rst_ni, cmd_i.drop |-> all_filled)
  `FSTA_ASSERT_NR(a_rst_out, clk_i, !rst_ni |=> !out_valid_q)

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the four-stream timestamp aligner with its own alignment predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fsta_pkg::*;

  // Depth of the frame queue kept per stream, the same as the block's default.
  localparam int unsigned QDEPTH = QueueDepthDef;
  // Cycles to let pass after the last set, so that a trail of drops can finish.
  localparam int unsigned DRAIN_CYCLES = 150;
  // Length of the one long hold-off of the receiver.
  localparam int unsigned LONG_HOLD = 300;
  // Cycles without any transfer after which the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 4000;
  // Room for every planned frame and every predicted set of the whole run.
  localparam int unsigned PLAN_CAP = 4096;
  localparam logic [StampBits-1:0] STAMP_MAX = '1;

  // One input frame as the driver offers it.
  typedef struct packed {
    logic [StreamBits-1:0] stream;
    logic [StampBits-1:0]  stamp;
    logic [InTagBits-1:0]  tag;
  } frame_t;

  // One synchronized set. The layout matches m_axis_tdata: stamps of streams 0..3 from
  // bit 0 up, then the four tags above them.
  typedef struct packed {
    logic [NumStreams-1:0][OutTagBits-1:0] tag;
    logic [NumStreams-1:0][StampBits-1:0]  stamp;
  } sync_set_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [63:0]            s_axis_tdata = '0;
  logic [StreamBits-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [TolBits-1:0]     cfg_data_i = '0;

  four_stream_timestamp_aligner_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: a mirror of the four frame queues and of the tolerance register.
  frame_t             lane_mem [NumStreams][QDEPTH];
  int unsigned        lane_head [NumStreams];
  int unsigned        lane_cnt [NumStreams];
  logic [TolBits-1:0] tol_model = TolReset;
  // Sets the block owes us, oldest first, between the read and write indexes.
  sync_set_t          due_mem [PLAN_CAP];
  int unsigned        due_wr = 0;
  int unsigned        due_rd = 0;
  int unsigned        errors = 0;

  // Frames waiting to be offered, filled by the stimulus process.
  frame_t      pend_mem [PLAN_CAP];
  int unsigned pend_wr = 0;
  int unsigned pend_rd = 0;
  frame_t      offered = '0;
  bit          offer_live = 1'b0;
  int unsigned src_wait = 0;
  int unsigned sink_wait = 0;
  // Idle profile of the current phase; zero means no idling on that side.
  int unsigned src_gap_max = 0;
  int unsigned sink_gap_max = 0;
  // Long hold-off requests, served and counted down by the receiver itself.
  int unsigned hold_asks = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;

  // Drops the head entry of one stream queue.
  function automatic void pop_lane(input int unsigned s);
    if (lane_cnt[s] != 0) begin
      lane_head[s] = (lane_head[s] + 1) % QDEPTH;
      lane_cnt[s]--;
    end
  endfunction

  // Appends one frame to its stream queue and then aligns the heads. Stale heads are
  // dropped one at a time, oldest first with ties to the lowest stream, until either a
  // set within tolerance is found or some queue runs dry.
  task automatic align_frame(input frame_t f);
    int unsigned      s;
    int unsigned      oldest;
    logic [StampBits-1:0] lo;
    logic [StampBits-1:0] hi;
    logic [StampBits-1:0] h;
    sync_set_t        made;
    bit               searching;
    // A full queue gives up its own oldest frame to make room.
    if (lane_cnt[f.stream] == QDEPTH) pop_lane(f.stream);
    lane_mem[f.stream][(lane_head[f.stream] + lane_cnt[f.stream]) % QDEPTH] = f;
    lane_cnt[f.stream]++;
    searching = 1'b1;
    while (searching && lane_cnt[0] != 0 && lane_cnt[1] != 0 &&
           lane_cnt[2] != 0 && lane_cnt[3] != 0) begin
      lo = lane_mem[0][lane_head[0]].stamp;
      hi = lo;
      oldest = 0;
      for (s = 1; s < NumStreams; s++) begin
        h = lane_mem[s][lane_head[s]].stamp;
        if (h < lo) begin
          lo = h;
          oldest = s;
        end
        if (h > hi) hi = h;
      end
      if (hi - lo <= {16'd0, tol_model}) begin
        for (s = 0; s < NumStreams; s++) begin
          made.stamp[s] = lane_mem[s][lane_head[s]].stamp;
          made.tag[s]   = lane_mem[s][lane_head[s]].tag;
          pop_lane(s);
        end
        due_mem[due_wr] = made;
        due_wr++;
        searching = 1'b0;
      end else begin
        pop_lane(oldest);
      end
    end
  endtask

  // Driver: predicts each frame at its input transfer, then either waits out the gap
  // drawn for the next frame or loads it from the pending list. Valid gets exactly one
  // nonblocking update per edge, so back-to-back frames keep it high.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        align_frame(offered);
        offer_live = 1'b0;
        src_wait = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
      end
      if (!offer_live) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (pend_rd != pend_wr) begin
          offered = pend_mem[pend_rd];
          pend_rd++;
          offer_live = 1'b1;
        end
      end
      s_axis_tvalid <= offer_live;
      s_axis_tdata  <= {offered.tag, offered.stamp};
      s_axis_tuser  <= offered.stream;
    end
  end

  // Monitor: checks each set field by field against the oldest prediction and decides
  // when to take the next one. A long hold-off takes precedence over the per-set stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_rd == due_wr) begin
          $display("%0t: set with none expected: %h", $time, m_axis_tdata);
          errors++;
        end else begin
          sync_set_t want;
          sync_set_t got;
          want = due_mem[due_rd];
          due_rd++;
          got = m_axis_tdata;
          for (int s = 0; s < NumStreams; s++) begin
            if (got.stamp[s] !== want.stamp[s]) begin
              $display("%0t: stamp of stream %0d expected %h, got %h",
                       $time, s, want.stamp[s], got.stamp[s]);
              errors++;
            end
            if (got.tag[s] !== want.tag[s]) begin
              $display("%0t: tag of stream %0d expected %h, got %h",
                       $time, s, want.tag[s], got.tag[s]);
              errors++;
            end
          end
        end
        sink_wait = (sink_gap_max == 0) ? 0 : $urandom_range(0, sink_gap_max);
      end
      if (hold_served != hold_asks) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count of quiet cycles.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic add_frame(input int unsigned stream, input logic [StampBits-1:0] stamp,
                           input logic [InTagBits-1:0] tag);
    frame_t f;
    f.stream = stream[StreamBits-1:0];
    f.stamp  = stamp;
    f.tag    = tag;
    pend_mem[pend_wr] = f;
    pend_wr++;
  endtask

  // Waits until every frame has been taken and every set has arrived, then lets the
  // block finish any trailing drops. Sampled at the falling edge, after all updates.
  task automatic wait_idle();
    do @(negedge clk_i); while (pend_rd != pend_wr || offer_live || due_rd != due_wr);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TolBits-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tol_model = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Plans camera-like traffic: rounds of one frame per stream in random order with
  // stamps spread within the tolerance, time moving forward between rounds. Mixed in
  // are rounds that miss a stream or repeat one, rounds that sit exactly on or just past
  // the tolerance, bursts that overflow one queue, and stray frames.
  task automatic plan_rounds(input int unsigned count);
    logic [StampBits-1:0] base;
    logic [StampBits-1:0] stamp;
    int unsigned order [NumStreams];
    int unsigned added;
    int unsigned kind;
    int unsigned j;
    int unsigned k;
    int unsigned tmp;
    int unsigned n;
    base  = {2'b00, 14'($urandom()), $urandom()};
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 19);
      for (j = 0; j < NumStreams; j++) order[j] = j;
      for (j = NumStreams - 1; j > 0; j--) begin
        k = $urandom_range(0, j);
        tmp = order[j];
        order[j] = order[k];
        order[k] = tmp;
      end
      if (kind == 0) begin
        // A stray frame, either anywhere in time or somewhere near the current round.
        stamp = $urandom_range(0, 1) ? {16'($urandom()), $urandom()} : base + $urandom();
        add_frame(order[0], stamp, 16'($urandom()));
        added++;
      end else if (kind == 1) begin
        // More frames on one stream than its queue holds.
        n = $urandom_range(QDEPTH + 1, QDEPTH + 3);
        for (j = 0; j < n; j++) begin
          add_frame(order[0], base + j, 16'($urandom()));
        end
        added += n;
      end else begin
        for (j = 0; j < NumStreams; j++) begin
          // One stream left out of this round.
          if (kind == 2 && j == NumStreams - 1) continue;
          stamp = base + $urandom_range(0, tol_model);
          if (kind >= 4 && kind <= 6 && j == 0) stamp = base;
          if (kind >= 4 && kind <= 6 && j == 1) begin
            // Spread exactly at the tolerance, or one tick past it.
            stamp = base + tol_model + ((kind == 4) ? 1 : 0);
          end
          // One stream sends an extra frame ahead of its real one.
          if (kind == 3 && j == 0) begin
            add_frame(order[j], base + $urandom_range(0, tol_model), 16'($urandom()));
            added++;
          end
          add_frame(order[j], stamp, 16'($urandom()));
          added++;
        end
      end
      base = base + tol_model + 1 + $urandom_range(0, 4095);
    end
  endtask

  // Runs one phase: new tolerance while idle, then random traffic under the given idle
  // profile, then a pause of the sender until every set has come back.
  task automatic run_phase(input logic [TolBits-1:0] tol, input int unsigned count,
                           input int unsigned src_max, input int unsigned sink_max,
                           input bit long_hold);
    write_tolerance(tol);
    @(negedge clk_i);
    src_gap_max  = src_max;
    sink_gap_max = sink_max;
    plan_rounds(count);
    if (long_hold) hold_asks++;
    wait_idle();
  endtask

  initial begin
    logic [StampBits-1:0] t;
    logic [StampBits-1:0] b;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset tolerance, which is left unwritten here.
    @(negedge clk_i);
    src_gap_max  = 16;
    sink_gap_max = 16;
    t = {16'd0, tol_model};
    // Zero stamps and a spread exactly equal to the tolerance give one set.
    add_frame(0, '0, 16'h0000);
    add_frame(1, t, 16'hFFFF);
    add_frame(2, '0, 16'h5A5A);
    add_frame(3, t, 16'hA5A5);
    // Stream 1 overflows and loses its first frame; then one stale head is dropped
    // before the set lines up.
    b = 48'h0001_0000_0000;
    for (int i = 0; i <= QDEPTH; i++) add_frame(1, b + i * t, 16'h1000 + i);
    add_frame(0, b + 3 * t, 16'h2000);
    add_frame(2, b + 3 * t, 16'h2001);
    add_frame(3, b + 3 * t, 16'h2002);
    // Top of the stamp range: a tie for the oldest head goes to the lower stream, a
    // spread one past the tolerance drops again, and the exact spread completes a set.
    add_frame(0, STAMP_MAX, 16'hFFFF);
    add_frame(1, STAMP_MAX - t - 1, 16'h0000);
    add_frame(2, STAMP_MAX - t - 1, 16'h0001);
    add_frame(3, STAMP_MAX, 16'h0002);
    add_frame(1, STAMP_MAX - 1, 16'h0003);
    add_frame(2, STAMP_MAX - t, 16'h0004);
    wait_idle();

    // Random phases across the tolerance range. The second one holds the receiver off
    // for a long stretch while the sender keeps pushing, so the block backs up.
    run_phase('0, 200, 16, 16, 1'b0);
    run_phase(TolReset, 200, 0, 4, 1'b1);
    run_phase('1, 200, 4, 0, 1'b0);
    run_phase($urandom(), 200, 16, 16, 1'b0);
    run_phase(32'd1000, 200, 0, 0, 1'b0);
    run_phase(32'd1, 230, 16, 16, 1'b0);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
